[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/fqoc_pkg.sv]
// ----------------------------------------------------------------------------
// fqoc_pkg
// Types and constants shared by the ordered FIFO queue modules.
// ----------------------------------------------------------------------------
package fqoc_pkg;

  // Built ring depth. The 5-bit capacity and occupancy fields must be able to
  // hold this depth as a value, so it is fixed together with them.
  localparam int DEPTH     = 16;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;
  localparam int CNT_W     = 5;
  localparam int OUT_W     = 104;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_STATUS = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the input word and read the second-oldest entry
    logic commit;   // apply the operation and load the result register
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    status_e                  status;
    logic [CNT_W-1:0]         occupancy;
    logic                     is_full;
    logic                     is_empty;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     is_ordered;
  } result_t;

endpackage

[design/fqoc_ctrl.sv]
// ----------------------------------------------------------------------------
// fqoc_ctrl
// Handshake controller: accepts one word, then commits it once the result
// register is free.
// ----------------------------------------------------------------------------
module fqoc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fqoc_pkg::cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   res_free;

  // The result register can take a new word when empty or being drained.
  assign res_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d        = state_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    cmd_o.capture  = 1'b0;
    cmd_o.commit   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (res_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[design/fqoc_dpath.sv]
// ----------------------------------------------------------------------------
// fqoc_dpath
// Ring storage, pointers, descent counter and result register.
// ----------------------------------------------------------------------------
module fqoc_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fqoc_pkg::cmd_t                      cmd_i,
  input  logic [fqoc_pkg::OP_W-1:0]           op_i,
  input  logic signed [fqoc_pkg::DATA_W-1:0]  value_i,
  input  logic                                cfg_we_i,
  input  logic [fqoc_pkg::CNT_W-1:0]          cfg_wdata_i,
  output fqoc_pkg::result_t                   result_o
);

  localparam int PW = (fqoc_pkg::DEPTH > 1) ? $clog2(fqoc_pkg::DEPTH) : 1;
  localparam int SW = PW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(fqoc_pkg::DEPTH);

  logic signed [fqoc_pkg::DATA_W-1:0] mem [fqoc_pkg::DEPTH];

  logic [fqoc_pkg::CNT_W-1:0]         cap_q;
  logic [PW-1:0]                      head_q, head_d;
  logic [fqoc_pkg::CNT_W-1:0]         count_q, count_d;
  logic [fqoc_pkg::CNT_W-1:0]         desc_q, desc_d;
  logic signed [fqoc_pkg::DATA_W-1:0] front_q, front_d;
  logic signed [fqoc_pkg::DATA_W-1:0] rear_q, rear_d;
  logic [fqoc_pkg::OP_W-1:0]          op_q;
  logic signed [fqoc_pkg::DATA_W-1:0] val_q;
  logic signed [fqoc_pkg::DATA_W-1:0] rd_data_q;
  fqoc_pkg::result_t                  res_q, res_d;

  logic [fqoc_pkg::CNT_W-1:0] cap_eff;
  logic [SW-1:0]              nxt_sum, wr_sum;
  logic [PW-1:0]              nxt_slot, wr_slot;
  logic                       full, empty, push_ok;

  // Capacity zero acts as one; anything above the built depth saturates.
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = fqoc_pkg::CNT_W'(1);
    end else if (int'(cap_q) > fqoc_pkg::DEPTH) begin
      cap_eff = fqoc_pkg::CNT_W'(fqoc_pkg::DEPTH);
    end else begin
      cap_eff = cap_q;
    end
  end

  // Ring addresses: the entry after the head, and the free place at the rear.
  assign nxt_sum  = {1'b0, head_q} + SW'(1);
  assign nxt_slot = PW'((nxt_sum >= DEPTH_S) ? nxt_sum - DEPTH_S : nxt_sum);
  assign wr_sum   = {1'b0, head_q} + SW'(count_q);
  assign wr_slot  = PW'((wr_sum >= DEPTH_S) ? wr_sum - DEPTH_S : wr_sum);

  assign full    = (count_q >= cap_eff);
  assign empty   = (count_q == '0);
  assign push_ok = (op_q == fqoc_pkg::OP_PUSH) && !full;

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    desc_d  = desc_q;
    front_d = front_q;
    rear_d  = rear_q;
    res_d.popped_value = '0;
    res_d.status       = fqoc_pkg::ST_OK;

    if (op_q == fqoc_pkg::OP_PUSH) begin
      if (full) begin
        res_d.status = fqoc_pkg::ST_FULL;
      end else begin
        if (empty) begin
          front_d = val_q;
        end else if (rear_q > val_q) begin
          desc_d = desc_q + fqoc_pkg::CNT_W'(1);
        end
        rear_d  = val_q;
        count_d = count_q + fqoc_pkg::CNT_W'(1);
      end
    end else if (op_q == fqoc_pkg::OP_POP) begin
      if (empty) begin
        res_d.status = fqoc_pkg::ST_EMPTY;
      end else begin
        res_d.popped_value = front_q;
        // rd_data_q holds the entry behind the head, read at capture time.
        if (count_q > fqoc_pkg::CNT_W'(1)) begin
          if ((front_q > rd_data_q) && (desc_q != '0)) begin
            desc_d = desc_q - fqoc_pkg::CNT_W'(1);
          end
          front_d = rd_data_q;
        end
        head_d  = nxt_slot;
        count_d = count_q - fqoc_pkg::CNT_W'(1);
      end
    end

    res_d.occupancy   = count_d;
    res_d.is_full     = (count_d >= cap_eff);
    res_d.is_empty    = (count_d == '0);
    res_d.front_value = (count_d != '0) ? front_d : '0;
    res_d.rear_value  = (count_d != '0) ? rear_d : '0;
    res_d.is_ordered  = (desc_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= fqoc_pkg::CAP_RESET;
      head_q  <= '0;
      count_q <= '0;
      desc_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        head_q  <= head_d;
        count_q <= count_d;
        desc_q  <= desc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= op_i;
      val_q     <= value_i;
      rd_data_q <= mem[nxt_slot];
    end
    if (cmd_i.commit) begin
      front_q <= front_d;
      rear_q  <= rear_d;
      res_q   <= res_d;
      if (push_ok) begin
        mem[wr_slot] <= val_q;
      end
    end
  end

  assign result_o = res_q;

endmodule

[design/fifo_queue_with_order_check.sv]
// ----------------------------------------------------------------------------
// fifo_queue_with_order_check
// Bounded FIFO of signed 32-bit values with status peeks and an order check.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload
//   s_axis    in         tuser: operation; tdata: push_value
//   m_axis    out        tuser: status; tdata: popped_value .. is_ordered
//   cfg       in         cfg_wdata_i: capacity
//
// For each word, the accept cycle reads the entry behind the head out of
// the single-read-port ring memory; a later commit cycle then applies the
// operation and loads the result register. The block takes a new word
// while a finished result still waits on m_axis; that word then stalls in
// its commit cycle until the result register drains. Reset clears pointers,
// counters and capacity (to 16); the ring contents are not cleared, since
// only entries written by a push are ever read.
// ----------------------------------------------------------------------------
module fifo_queue_with_order_check (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input words.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [31:0] push_value
  input  logic [31:0]                    s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]                     s_axis_tuser,
  // Result words.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [31:0] popped_value, [36:32] occupancy, [37] is_full, [38] is_empty,
  // [70:39] front_value, [102:71] rear_value, [103] is_ordered
  output logic [fqoc_pkg::OUT_W-1:0]     m_axis_tdata,
  // [1:0] status
  output logic [fqoc_pkg::STAT_W-1:0]    m_axis_tuser,
  // Capacity register write.
  input  logic                           cfg_we_i,
  input  logic [fqoc_pkg::CNT_W-1:0]     cfg_wdata_i
);

  `include "assert_macros.svh"

  fqoc_pkg::cmd_t    cmd;
  fqoc_pkg::result_t res;

  // The controller owns the handshakes; it never looks at payload.
  fqoc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // The datapath holds the ring, pointers, descent count and result register.
  fqoc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .op_i        (s_axis_tuser),
    .value_i     (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (res)
  );

  // Result fields are packed from the lowest bit up in the order listed above.
  assign m_axis_tdata = {res.is_ordered, res.rear_value, res.front_value,
                         res.is_empty, res.is_full, res.occupancy,
                         res.popped_value};
  assign m_axis_tuser = res.status;

  // One word at a time: an accepted word blocks the input for the next cycle.
  `ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready,
    "input accepted while previous word still in progress")

  // An empty queue reports zero peeks and counts as ordered.
  `ASSERT_SAME(a_empty_peeks, m_axis_tvalid && res.is_empty,
    (res.occupancy == '0) && (res.front_value == '0) && (res.rear_value == '0)
      && res.is_ordered,
    "empty result with nonzero peeks or occupancy")

  // A dropped push leaves the queue full.
  `ASSERT_SAME(a_drop_full, m_axis_tvalid && (res.status == fqoc_pkg::ST_FULL),
    res.is_full, "push dropped while queue not full")

  // A pop on empty returns zero and leaves the queue empty.
  `ASSERT_SAME(a_pop_empty, m_axis_tvalid && (res.status == fqoc_pkg::ST_EMPTY),
    res.is_empty && (res.popped_value == '0), "empty pop with data or entries")

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded FIFO queue with the running order check.
// ----------------------------------------------------------------------------
//
// Input words go in on s_axis and result words come back on m_axis. An
// in-bench model of the ring tracks the head, the element count, the number
// of adjacent descents and the capacity register. It produces one expected
// result for every accepted input word. Each accepted result word is compared
// field by field with the oldest expected result.
//
// The run has two parts. First comes a short directed plan. It covers the
// empty queue after reset, a pop on an empty queue, the extreme values,
// unused operation code 3, and a capacity lowered below the occupancy.
// Capacity zero and capacity above the depth are covered too. Then come
// random phases, each with its own capacity. Most pushed values climb slowly,
// so the order flag stays set over long stretches and each descent means
// something. Both sides idle in random bursts, and the last phases run
// without gaps.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [31:0] VAL_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_MIN  = 32'h8000_0000;
  localparam logic [1:0]  OP_SPARE = 2'd3;   // Unused code, acts as status only.
  localparam int          PHASES   = 16;
  localparam int          PHASE_LEN = 100;

  typedef enum logic {ROW_WORD, ROW_CAP} row_kind_e;

  // One row of the directed plan. A row with "typed" set carries its expected
  // result written out by hand, and every other row is checked against the
  // model. A capacity row carries the new register value in "value".
  typedef struct packed {
    row_kind_e         kind;
    logic [1:0]        op;
    logic [31:0]       value;
    logic              typed;
    fqoc_pkg::result_t known;
  } plan_row_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [31:0]                   s_axis_tdata  = '0;
  logic [1:0]                    s_axis_tuser  = fqoc_pkg::OP_STATUS;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [fqoc_pkg::OUT_W-1:0]    m_axis_tdata;
  logic [fqoc_pkg::STAT_W-1:0]   m_axis_tuser;
  logic                          cfg_we_i      = 1'b0;
  logic [fqoc_pkg::CNT_W-1:0]    cfg_wdata_i   = fqoc_pkg::CAP_RESET;

  // Model of the queue as the block holds it.
  logic [31:0]          ring_q [16];
  logic [3:0]           head_q        = '0;
  logic [4:0]           fill_q        = '0;
  int                   descents_q    = 0;
  logic [4:0]           capacity_q    = fqoc_pkg::CAP_RESET;

  fqoc_pkg::result_t    pending_results [$];
  plan_row_t            warmup_plan [$];
  int                   mismatch_count = 0;
  bit                   quiet          = 1'b0;  // No idling on either side.
  bit                   long_hold_req  = 1'b0;  // Ask the sink for a long stall.

  always #1 clk_i = ~clk_i;

  fifo_queue_with_order_check u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Apply one operation to the model of the queue and return the result that
  // the block must give for it.
  function automatic fqoc_pkg::result_t apply_word(input logic [1:0] op,
                                                   input logic [31:0] value);
    fqoc_pkg::result_t r;
    logic [4:0]        room;
    logic [3:0]        slot;
    room = (capacity_q == 5'd0) ? 5'd1 : (capacity_q > 5'd16) ? 5'd16 : capacity_q;
    r = '0;
    r.status = fqoc_pkg::ST_OK;
    if (op == fqoc_pkg::OP_PUSH) begin
      if (fill_q >= room) begin
        r.status = fqoc_pkg::ST_FULL;
      end else begin
        // Compare the new value with the current rear before appending it.
        slot = head_q + 4'(fill_q - 5'd1);
        if (fill_q != 5'd0 && $signed(ring_q[slot]) > $signed(value)) descents_q++;
        slot = head_q + 4'(fill_q);
        ring_q[slot] = value;
        fill_q++;
      end
    end else if (op == fqoc_pkg::OP_POP) begin
      if (fill_q == 5'd0) begin
        r.status = fqoc_pkg::ST_EMPTY;
      end else begin
        r.popped_value = ring_q[head_q];
        // Removing the front also removes the descent that it starts, if any.
        slot = head_q + 4'd1;
        if (fill_q > 5'd1 && $signed(ring_q[head_q]) > $signed(ring_q[slot]) &&
            descents_q > 0) descents_q--;
        head_q = head_q + 4'd1;
        fill_q--;
      end
    end
    r.occupancy = fill_q;
    r.is_full   = (fill_q >= room);
    r.is_empty  = (fill_q == 5'd0);
    if (fill_q != 5'd0) begin
      slot = head_q + 4'(fill_q - 5'd1);
      r.front_value = ring_q[head_q];
      r.rear_value  = ring_q[slot];
    end
    r.is_ordered = (descents_q == 0);
    return r;
  endfunction

  function automatic void add_row(input row_kind_e kind, input logic [1:0] op,
                                  input logic [31:0] value, input logic typed,
                                  input fqoc_pkg::result_t known);
    warmup_plan.push_back('{kind, op, value, typed, known});
  endfunction

  // Offer one word, wait for it to be taken, and record what it must produce.
  // In an idle burst, tvalid goes low for a random gap before the word goes out.
  task automatic send_word(input logic [1:0] op, input logic [31:0] value,
                           input logic typed, input fqoc_pkg::result_t known);
    fqoc_pkg::result_t predicted;
    int                gap;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = apply_word(op, value);
    pending_results.push_back(typed ? known : predicted);
  endtask

  // Stop offering words and wait until every expected result is in. The block
  // then holds nothing in flight, since every word yields exactly one result.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Capacity writes happen only while the block is idle.
  task automatic write_capacity(input logic [4:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    capacity_q = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void check_field(input string name, input logic [31:0] expected,
                                      input logic [31:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, expected, actual);
      mismatch_count++;
    end
  endfunction

  // Result sink. It drives tready at the falling edge. It stalls in random
  // bursts, and it holds off for a long stretch when asked to, so that the
  // block fills up and stops taking input.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = 64;
      end else if (stall_left == 0 && !quiet && rst_ni && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Every result word taken at a rising edge is matched against the oldest
  // expected result.
  always @(posedge clk_i) begin
    fqoc_pkg::result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected, got tdata %0h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("popped_value", exp_r.popped_value, m_axis_tdata[31:0]);
        check_field("status", 32'(exp_r.status), 32'(m_axis_tuser));
        check_field("occupancy", 32'(exp_r.occupancy), 32'(m_axis_tdata[36:32]));
        check_field("is_full", 32'(exp_r.is_full), 32'(m_axis_tdata[37]));
        check_field("is_empty", 32'(exp_r.is_empty), 32'(m_axis_tdata[38]));
        check_field("front_value", exp_r.front_value, m_axis_tdata[70:39]);
        check_field("rear_value", exp_r.rear_value, m_axis_tdata[102:71]);
        check_field("is_ordered", 32'(exp_r.is_ordered), 32'(m_axis_tdata[103]));
      end
    end
  end

  initial begin : stimulus
    plan_row_t   row;
    logic [1:0]  op;
    logic [31:0] value;
    logic [31:0] ramp;
    logic [4:0]  cap;
    int          push_pct;
    int          pick;

    // Directed plan. It starts at the reset capacity of 16.
    add_row(ROW_WORD, fqoc_pkg::OP_STATUS, 32'h0, 1'b1,
            '{32'h0, fqoc_pkg::ST_OK, 5'd0, 1'b0, 1'b1, 32'h0, 32'h0, 1'b1});
    add_row(ROW_WORD, fqoc_pkg::OP_POP, 32'hFFFF_FFFF, 1'b1,
            '{32'h0, fqoc_pkg::ST_EMPTY, 5'd0, 1'b0, 1'b1, 32'h0, 32'h0, 1'b1});
    add_row(ROW_WORD, fqoc_pkg::OP_PUSH, VAL_MAX, 1'b1,
            '{32'h0, fqoc_pkg::ST_OK, 5'd1, 1'b0, 1'b0, VAL_MAX, VAL_MAX, 1'b1});
    // Largest followed by smallest is a descent.
    add_row(ROW_WORD, fqoc_pkg::OP_PUSH, VAL_MIN, 1'b1,
            '{32'h0, fqoc_pkg::ST_OK, 5'd2, 1'b0, 1'b0, VAL_MAX, VAL_MIN, 1'b0});
    add_row(ROW_WORD, OP_SPARE, 32'h5555_5555, 1'b0, '0);
    // Popping the front element also removes the descent.
    add_row(ROW_WORD, fqoc_pkg::OP_POP, 32'hAAAA_AAAA, 1'b1,
            '{VAL_MAX, fqoc_pkg::ST_OK, 5'd1, 1'b0, 1'b0, VAL_MIN, VAL_MIN, 1'b1});
    add_row(ROW_WORD, fqoc_pkg::OP_PUSH, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(ROW_WORD, fqoc_pkg::OP_PUSH, 32'h0, 1'b0, '0);
    add_row(ROW_WORD, fqoc_pkg::OP_PUSH, 32'h0, 1'b0, '0);
    add_row(ROW_WORD, fqoc_pkg::OP_PUSH, 32'hAAAA_AAAA, 1'b0, '0);
    // Lower the capacity below the occupancy. Pushes are dropped until pops
    // bring the count below the capacity.
    add_row(ROW_CAP, fqoc_pkg::OP_STATUS, 32'd2, 1'b0, '0);
    add_row(ROW_WORD, fqoc_pkg::OP_PUSH, 32'h1, 1'b0, '0);
    add_row(ROW_WORD, fqoc_pkg::OP_POP, 32'h0, 1'b0, '0);
    add_row(ROW_WORD, fqoc_pkg::OP_POP, 32'h0, 1'b0, '0);
    add_row(ROW_WORD, fqoc_pkg::OP_POP, 32'h0, 1'b0, '0);
    add_row(ROW_WORD, fqoc_pkg::OP_POP, 32'h0, 1'b0, '0);
    add_row(ROW_WORD, fqoc_pkg::OP_PUSH, 32'h5, 1'b0, '0);
    add_row(ROW_WORD, fqoc_pkg::OP_PUSH, 32'h6, 1'b0, '0);
    // Capacity zero behaves as one.
    add_row(ROW_CAP, fqoc_pkg::OP_STATUS, 32'd0, 1'b0, '0);
    add_row(ROW_WORD, fqoc_pkg::OP_POP, 32'h0, 1'b0, '0);
    add_row(ROW_WORD, fqoc_pkg::OP_PUSH, 32'h7, 1'b0, '0);
    // Capacity above the depth saturates to the depth.
    add_row(ROW_CAP, fqoc_pkg::OP_STATUS, 32'd31, 1'b0, '0);
    add_row(ROW_WORD, fqoc_pkg::OP_PUSH, 32'h1234_5678, 1'b0, '0);
    add_row(ROW_WORD, fqoc_pkg::OP_POP, 32'h0, 1'b0, '0);
    add_row(ROW_WORD, fqoc_pkg::OP_POP, 32'h0, 1'b0, '0);
    add_row(ROW_WORD, fqoc_pkg::OP_POP, 32'h0, 1'b0, '0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (warmup_plan[i]) begin
      row = warmup_plan[i];
      if (row.kind == ROW_CAP) begin
        write_capacity(row.value[4:0]);
      end else begin
        send_word(row.op, row.value, row.typed, row.known);
      end
    end

    // Random phases. Each phase sets a new capacity and then runs words whose
    // push share moves between filling, balanced and draining.
    ramp = $urandom;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 8)
        0:       cap = 5'd16;
        1:       cap = 5'd1;
        2:       cap = 5'd0;
        3:       cap = 5'd31;
        4:       cap = 5'($urandom_range(2, 6));
        5:       cap = 5'($urandom_range(17, 30));
        6:       cap = 5'($urandom_range(7, 15));
        default: cap = 5'($urandom_range(1, 16));
      endcase
      write_capacity(cap);
      quiet    = (phase >= PHASES - 2);
      push_pct = 85;
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (n % 25 == 24) begin
          case ($urandom_range(0, 2))
            0:       push_pct = 85;
            1:       push_pct = 50;
            default: push_pct = 15;
          endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < push_pct)  op = fqoc_pkg::OP_PUSH;
        else if (pick < 96)   op = fqoc_pkg::OP_POP;
        else if (pick < 98)   op = fqoc_pkg::OP_STATUS;
        else                  op = OP_SPARE;
        // Most values climb slowly, with equal neighbors and rare drops. The
        // rest are full-range or extreme values.
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          if ($urandom_range(0, 9) == 0) ramp = ramp - $urandom_range(1, 5000);
          else                           ramp = ramp + $urandom_range(0, 3);
          value = ramp;
        end else if (pick < 90) begin
          value = $urandom;
        end else begin
          case ($urandom_range(0, 5))
            0:       value = VAL_MAX;
            1:       value = VAL_MIN;
            2:       value = 32'h0;
            3:       value = 32'hFFFF_FFFF;
            4:       value = 32'h1;
            default: value = 32'h8000_0001;
          endcase
        end
        send_word(op, value, 1'b0, '0);
        // Long stall at the sink while words keep coming, so that the block
        // backs up into its input.
        if (phase == 4 && n == 10) long_hold_req = 1'b1;
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
